// File: sv/qdec_pkg.sv
// Shared constants, types and helpers for the quadrature decoder with speed output.
package qdec_pkg;

	localparam int CountWidth = 32;
	localparam int PprWidth   = 16;
	localparam int TimeWidth  = 32;
	localparam int SpeedWidth = 40;
	localparam int ScaleWidth = 35;
	localparam int DenWidth   = PprWidth + TimeWidth;
	localparam int NumWidth   = CountWidth + ScaleWidth;
	localparam int CntWidth   = $clog2(NumWidth + 1);

	localparam logic [PprWidth-1:0]   PprReset   = PprWidth'(1024);
	localparam logic [ScaleWidth-1:0] SpeedScale = 35'd23040000000;

	localparam logic signed [1:0] StepTable [16] = '{
		2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
		-2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} qdec_state_t;

	typedef struct packed {
		logic take;
		logic mul_step;
		logic div_step;
		logic finish;
	} qdec_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic needs_div;
	} qdec_status_t;

	function automatic logic [31:0] to_count32(input logic signed [CountWidth-1:0] v);
		return 32'(v);
	endfunction

endpackage

// File: sv/qdec_ctrl.sv
// Controller: item acceptance and sequencing of the multiply and divide passes.
module qdec_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  qdec_pkg::qdec_status_t status,
	output qdec_pkg::qdec_cmd_t    cmd
);

	qdec_pkg::qdec_state_t              state_q, state_d;
	logic [qdec_pkg::CntWidth-1:0]      cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qdec_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		in_ready     = 1'b0;
		cmd          = '0;
		case (state_q)
			qdec_pkg::ST_IDLE: begin
				in_ready = status.slot_free;
				if (in_valid && status.slot_free) begin
					cmd.take = 1'b1;
					if (status.needs_div) begin
						state_d = qdec_pkg::ST_MUL;
						cnt_d   = qdec_pkg::CntWidth'(qdec_pkg::CountWidth - 1);
					end
				end
			end
			qdec_pkg::ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = qdec_pkg::ST_DIV;
					cnt_d   = qdec_pkg::CntWidth'(qdec_pkg::NumWidth - 1);
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			qdec_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = qdec_pkg::ST_DONE;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			qdec_pkg::ST_DONE: begin
				if (status.slot_free) begin
					cmd.finish = 1'b1;
					state_d    = qdec_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = qdec_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: sv/qdec_dp.sv
// Datapath: position counter, query registers, shift-add multiply, restoring divide, output.
module qdec_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [qdec_pkg::PprWidth-1:0]      cfg_wdata,
	input  logic                               in_command,
	input  logic                               in_chan_a,
	input  logic                               in_chan_b,
	input  logic [qdec_pkg::TimeWidth-1:0]     in_time_now,
	input  qdec_pkg::qdec_cmd_t                cmd,
	output qdec_pkg::qdec_status_t             status,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [31:0]                        out_count_now,
	output logic [qdec_pkg::SpeedWidth-1:0]    out_speed_value,
	output logic                               out_speed_updated,
	output logic                               out_zero_interval,
	output logic                               out_speed_saturated
);

	localparam int CW = qdec_pkg::CountWidth;
	localparam int NW = qdec_pkg::NumWidth;
	localparam int DW = qdec_pkg::DenWidth;
	localparam int SW = qdec_pkg::SpeedWidth;

	logic [qdec_pkg::PprWidth-1:0]  ppr_q;
	logic [1:0]                     prev_pair_q;
	logic [CW-1:0]                  pos_q;
	logic [CW-1:0]                  last_count_q;
	logic [qdec_pkg::TimeWidth-1:0] last_time_q;

	logic [CW-1:0] mag_q;
	logic          neg_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] prod_q;
	logic [DW-1:0] rem_q;
	logic [31:0]   count_hold_q;

	logic                            out_valid_q;
	logic [31:0]                     out_count_q;
	logic [SW-1:0]                   out_speed_q;
	logic                            out_upd_q;
	logic                            out_zero_q;
	logic                            out_sat_q;

	logic [1:0]                      pair;
	logic signed [1:0]               step;
	logic [CW-1:0]                   pos_next;
	logic [qdec_pkg::TimeWidth-1:0]  dt;
	logic [qdec_pkg::PprWidth-1:0]   ppr_eff;
	logic [CW:0]                     diff;
	logic [CW:0]                     diff_abs;
	logic [NW-1:0]                   prod_add;
	logic [DW:0]                     rem_sh;
	logic                            rem_ge;
	logic [DW:0]                     rem_sub;
	logic                            sat;
	logic [SW-1:0]                   mag_lim;
	logic [SW-1:0]                   speed;

	always_comb begin
		pair = {in_chan_b, in_chan_a};
		step = qdec_pkg::StepTable[{prev_pair_q, pair}];
		pos_next = (pair != prev_pair_q) ? pos_q + {{(CW-2){step[1]}}, step} : pos_q;
		dt = in_time_now - last_time_q;
		ppr_eff = (ppr_q == '0) ? qdec_pkg::PprWidth'(1) : ppr_q;
		diff = {pos_q[CW-1], pos_q} - {last_count_q[CW-1], last_count_q};
		diff_abs = diff[CW] ? (~diff + 1'b1) : diff;
		prod_add = {prod_q[NW-2:0], 1'b0}
			+ (mag_q[CW-1] ? NW'(qdec_pkg::SpeedScale) : '0);
		rem_sh = {rem_q, prod_q[NW-1]};
		rem_ge = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
		if (neg_q) begin
			sat = (prod_q[NW-1:SW] != '0) || (prod_q[SW-1] && (prod_q[SW-2:0] != '0));
			mag_lim = sat ? {1'b1, {(SW-1){1'b0}}} : prod_q[SW-1:0];
			speed = ~mag_lim + 1'b1;
		end else begin
			sat = prod_q[NW-1:SW-1] != '0;
			mag_lim = sat ? {1'b0, {(SW-1){1'b1}}} : prod_q[SW-1:0];
			speed = mag_lim;
		end
		status.slot_free = !out_valid_q || out_ready;
		status.needs_div = in_command && (dt != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q        <= qdec_pkg::PprReset;
			prev_pair_q  <= '0;
			pos_q        <= '0;
			last_count_q <= '0;
			last_time_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				ppr_q <= cfg_wdata;
			end
			if (cmd.take) begin
				if (!in_command) begin
					pos_q       <= pos_next;
					prev_pair_q <= pair;
				end else begin
					last_count_q <= pos_q;
					last_time_q  <= in_time_now;
				end
			end
			if ((cmd.take && !status.needs_div) || cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mag_q        <= diff_abs[CW-1:0];
			neg_q        <= diff[CW];
			den_q        <= ppr_eff * dt;
			prod_q       <= '0;
			rem_q        <= '0;
			count_hold_q <= qdec_pkg::to_count32(pos_q);
			if (!status.needs_div) begin
				out_speed_q <= '0;
				out_sat_q   <= 1'b0;
				out_upd_q   <= in_command;
				out_zero_q  <= in_command;
				out_count_q <= in_command ? qdec_pkg::to_count32(pos_q)
					: qdec_pkg::to_count32(pos_next);
			end
		end
		if (cmd.mul_step) begin
			prod_q <= prod_add;
			mag_q  <= {mag_q[CW-2:0], 1'b0};
		end
		if (cmd.div_step) begin
			rem_q  <= rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			prod_q <= {prod_q[NW-2:0], rem_ge};
		end
		if (cmd.finish) begin
			out_speed_q <= speed;
			out_sat_q   <= sat;
			out_upd_q   <= 1'b1;
			out_zero_q  <= 1'b0;
			out_count_q <= count_hold_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign out_count_now       = out_count_q;
	assign out_speed_value     = out_speed_q;
	assign out_speed_updated   = out_upd_q;
	assign out_zero_interval   = out_zero_q;
	assign out_speed_saturated = out_sat_q;

endmodule

// File: sv/quadrature_decoder_with_speed.sv
// Top level: four-times quadrature decoder with a speed query.
//
//   channel   direction  tdata (low bit up)                          tuser
//   s_axis    in         chan_a, chan_b, time_now[31:0], pad         command
//   m_axis    out        count_now[31:0], speed_value[39:0],         speed_updated
//                        zero_interval, speed_saturated, pad
//   cfg       in         pulses_per_rev[15:0] on cfg_wdata when cfg_wen
//
// A pin sample or a query with zero elapsed time skips the multiply and divide
// passes; back-to-back items flow at one per cycle while the output register drains.
// A query with nonzero elapsed time runs a one-bit-a-cycle shift-add multiply, then a
// one-bit-a-cycle restoring divide in the shared datapath. Reset clears position and
// query state and loads pulses_per_rev with 1024. A stalled output holds the next item off.
module quadrature_decoder_with_speed (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // chan_a, chan_b, time_now[31:0], zero pad
	input  logic [0:0]  s_axis_tuser,  // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,  // count_now, speed_value, zero_interval,
	                                   // speed_saturated, zero pad
	output logic [0:0]  m_axis_tuser   // speed_updated
);

	qdec_pkg::qdec_cmd_t    cmd;
	qdec_pkg::qdec_status_t status;

	logic [31:0] count_now;
	logic [39:0] speed_value;
	logic        speed_updated;
	logic        zero_interval;
	logic        speed_saturated;

	qdec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	qdec_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_wen             (cfg_wen),
		.cfg_wdata           (cfg_wdata),
		.in_command          (s_axis_tuser[0]),
		.in_chan_a           (s_axis_tdata[0]),
		.in_chan_b           (s_axis_tdata[1]),
		.in_time_now         (s_axis_tdata[33:2]),
		.cmd                 (cmd),
		.status              (status),
		.out_ready           (m_axis_tready),
		.out_valid           (m_axis_tvalid),
		.out_count_now       (count_now),
		.out_speed_value     (speed_value),
		.out_speed_updated   (speed_updated),
		.out_zero_interval   (zero_interval),
		.out_speed_saturated (speed_saturated)
	);

	assign m_axis_tdata = {6'b0, speed_saturated, zero_interval, speed_value, count_now};
	assign m_axis_tuser = speed_updated;

endmodule

// File: bench/tb_quadrature_decoder_with_speed.sv
// Self-checking bench for the quadrature decoder: directed table, then random stream.
module tb_quadrature_decoder_with_speed;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 110;
	localparam int HOLD_AT      = 500;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASES       = 6;

	localparam logic [63:0] DEG_SCALE = 64'd23040000000;
	localparam int STEP_DELTA [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
	localparam logic [1:0] GRAY_ORDER [4] = '{2'd0, 2'd2, 2'd3, 2'd1};

	typedef struct packed {
		logic                           cmd;
		logic                           chan_a;
		logic                           chan_b;
		logic [qdec_pkg::TimeWidth-1:0] stamp;
	} enc_item_t;

	typedef struct packed {
		logic signed [31:0]                     count_now;
		logic signed [qdec_pkg::SpeedWidth-1:0] speed_value;
		logic                                   speed_updated;
		logic                                   zero_interval;
		logic                                   speed_saturated;
	} enc_reading_t;

	typedef struct packed {
		logic                          is_cfg;
		logic [qdec_pkg::PprWidth-1:0] ppr;
		enc_item_t                     item;
		logic                          typed;
		enc_reading_t                  want;
	} dir_row_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_wen       = 1'b0;
	logic [15:0] cfg_wdata     = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata  = '0;  // chan_a, chan_b, time_now[31:0], zero pad
	logic [0:0]  s_axis_tuser  = '0;  // command
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;        // count_now, speed_value, zero_interval,
	                                  // speed_saturated, pad
	logic [0:0]  m_axis_tuser;        // speed_updated

	logic [1:0]                     enc_pair;
	logic [31:0]                    enc_pos;
	logic [31:0]                    mark_pos;
	logic [qdec_pkg::TimeWidth-1:0] mark_stamp;
	logic [qdec_pkg::PprWidth-1:0]  ppr_cfg;

	int                             gen_step;
	int                             gen_dir;
	logic [qdec_pkg::TimeWidth-1:0] gen_stamp;

	enc_reading_t pending_readings [$];
	dir_row_t     dir_table [$];
	logic [qdec_pkg::PprWidth-1:0] phase_ppr [PHASES];
	int phase_items [PHASES] = '{200, 250, 150, 250, 250, 150};
	int phase_qpct  [PHASES] = '{3, 10, 4, 12, 10, 20};

	int mismatch_count = 0;
	int readings_seen  = 0;
	int hold_left      = 0;
	int stall_cycles   = 0;
	bit held           = 1'b0;
	bit calm           = 1'b0;

	quadrature_decoder_with_speed dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic enc_reading_t decode_item(input enc_item_t it);
		enc_reading_t       r;
		logic [1:0]         pair;
		logic [31:0]        dt;
		logic signed [32:0] delta;
		logic [32:0]        mag;
		logic [127:0]       quo;
		logic [127:0]       lim;
		logic               neg;
		r = '0;
		if (it.cmd == CMD_SAMPLE) begin
			pair = {it.chan_b, it.chan_a};
			if (pair != enc_pair) begin
				enc_pos = enc_pos + 32'(STEP_DELTA[{enc_pair, pair}]);
				enc_pair = pair;
			end
		end else begin
			dt = it.stamp - mark_stamp;
			r.speed_updated = 1'b1;
			if (dt == '0) begin
				r.zero_interval = 1'b1;
			end else begin
				delta = $signed({enc_pos[31], enc_pos}) - $signed({mark_pos[31], mark_pos});
				neg = delta[32];
				mag = neg ? 33'(-delta) : 33'(delta);
				quo = (128'(mag) * 128'(DEG_SCALE)) /
					(128'((ppr_cfg == '0) ? 16'd1 : ppr_cfg) * 128'(dt));
				lim = (128'(1) << (qdec_pkg::SpeedWidth - 1));
				if (!neg)
					lim = lim - 128'(1);
				if (quo > lim) begin
					quo = lim;
					r.speed_saturated = 1'b1;
				end
				r.speed_value = neg ? qdec_pkg::SpeedWidth'(-quo)
					: qdec_pkg::SpeedWidth'(quo);
			end
			mark_pos = enc_pos;
			mark_stamp = it.stamp;
		end
		r.count_now = enc_pos;
		return r;
	endfunction

	function automatic dir_row_t row(input logic cmd, input logic a, input logic b,
			input logic [31:0] stamp, input logic typed, input logic signed [31:0] cnt,
			input logic zero);
		dir_row_t r;
		r = '0;
		r.item = '{cmd, a, b, stamp};
		r.typed = typed;
		r.want = '{cnt, 40'sd0, cmd, zero, 1'b0};
		return r;
	endfunction

	function automatic dir_row_t cfg_row(input logic [qdec_pkg::PprWidth-1:0] v);
		dir_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.ppr = v;
		return r;
	endfunction

	function automatic enc_item_t next_random(input int query_pct);
		enc_item_t it;
		int        roll;
		it.cmd = CMD_SAMPLE;
		it.chan_a = 1'($urandom_range(1));
		it.chan_b = 1'($urandom_range(1));
		it.stamp = $urandom;
		roll = $urandom_range(99);
		if (roll < query_pct) begin
			it.cmd = CMD_QUERY;
			roll = $urandom_range(99);
			if (roll < 8)
				it.stamp = gen_stamp;
			else if (roll < 20)
				it.stamp = $urandom;
			else if (roll < 30)
				it.stamp = gen_stamp + $urandom_range(1000000, 1);
			else
				it.stamp = gen_stamp + $urandom_range(8, 1);
			gen_stamp = it.stamp;
		end else if (roll < query_pct + 5) begin
			foreach (GRAY_ORDER[k])
				if (GRAY_ORDER[k] == {it.chan_b, it.chan_a})
					gen_step = k;
		end else begin
			if ($urandom_range(99) < 4)
				gen_dir = -gen_dir;
			if ($urandom_range(99) >= 10)
				gen_step = (gen_step + gen_dir) & 3;
			{it.chan_b, it.chan_a} = GRAY_ORDER[gen_step];
		end
		return it;
	endfunction

	task automatic send_item(input enc_item_t it, input logic typed, input enc_reading_t want);
		enc_reading_t predicted;
		while (!calm && $urandom_range(99) < 20) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'b0, it.stamp, it.chan_b, it.chan_a};
		s_axis_tuser  <= it.cmd;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		predicted = decode_item(it);
		pending_readings.push_back(typed ? want : predicted);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_ppr(input logic [qdec_pkg::PprWidth-1:0] v);
		wait_drained();
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		ppr_cfg = v;
	endtask

	// check each reading and pace the receiver
	always @(posedge clk) begin
		enc_reading_t got;
		enc_reading_t want;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			got = '{m_axis_tdata[31:0], m_axis_tdata[71:32], m_axis_tuser[0],
				m_axis_tdata[72], m_axis_tdata[73]};
			readings_seen++;
			if (pending_readings.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected reading: count %0d speed %0d upd %b zero %b sat %b",
						got.count_now, got.speed_value, got.speed_updated,
						got.zero_interval, got.speed_saturated);
				mismatch_count++;
			end else begin
				want = pending_readings.pop_front();
				if (got !== want) begin
					if (mismatch_count < 10)
						$display({"reading %0d mismatch (exp/got): count %0d/%0d speed %0d/%0d",
							" upd %b/%b zero %b/%b sat %b/%b"}, readings_seen,
							want.count_now, got.count_now, want.speed_value, got.speed_value,
							want.speed_updated, got.speed_updated, want.zero_interval,
							got.zero_interval, want.speed_saturated, got.speed_saturated);
					mismatch_count++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (!held && readings_seen >= HOLD_AT) begin
			held = 1'b1;
			hold_left = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(99) >= 20);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready === 1'b1) ||
				(m_axis_tvalid === 1'b1 && m_axis_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_quadrature_decoder_with_speed: errors");
			$finish;
		end
	end

	initial begin
		enc_pair   = '0;
		enc_pos    = '0;
		mark_pos   = '0;
		mark_stamp = '0;
		ppr_cfg    = qdec_pkg::PprReset;
		gen_dir    = 1;
		phase_ppr  = '{16'd1, 16'd65535, 16'd0, 16'd1024, 16'($urandom_range(65534, 2)), 16'd3};
		dir_table = '{
			row(CMD_SAMPLE, 1'b0, 1'b0, 32'h0000_0000, 1'b1, 32'sd0, 1'b0),
			row(CMD_QUERY,  1'b0, 1'b0, 32'h0000_0000, 1'b1, 32'sd0, 1'b1),
			row(CMD_SAMPLE, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'sd1, 1'b0),
			row(CMD_SAMPLE, 1'b1, 1'b1, 32'h0000_0000, 1'b0, 32'sd0, 1'b0),
			row(CMD_SAMPLE, 1'b1, 1'b0, 32'h0000_0000, 1'b0, 32'sd0, 1'b0),
			row(CMD_SAMPLE, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 32'sd0, 1'b0),
			row(CMD_SAMPLE, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 32'sd0, 1'b0),
			row(CMD_QUERY,  1'b0, 1'b0, 32'h0000_0001, 1'b0, 32'sd0, 1'b0),
			row(CMD_SAMPLE, 1'b1, 1'b0, 32'h1234_5678, 1'b0, 32'sd0, 1'b0),
			row(CMD_SAMPLE, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 32'sd0, 1'b0),
			row(CMD_SAMPLE, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 32'sd0, 1'b0),
			row(CMD_QUERY,  1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'sd0, 1'b0),
			row(CMD_QUERY,  1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'sd2, 1'b1),
			row(CMD_QUERY,  1'b0, 1'b0, 32'h0000_0000, 1'b0, 32'sd0, 1'b0),
			row(CMD_SAMPLE, 1'b1, 1'b1, 32'h0000_0000, 1'b0, 32'sd0, 1'b0),
			row(CMD_SAMPLE, 1'b1, 1'b0, 32'h0000_0000, 1'b0, 32'sd0, 1'b0),
			row(CMD_QUERY,  1'b0, 1'b0, 32'h0000_0005, 1'b0, 32'sd0, 1'b0),
			row(CMD_SAMPLE, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'sd0, 1'b0),
			row(CMD_QUERY,  1'b1, 1'b0, 32'hAAAA_AAAA, 1'b0, 32'sd0, 1'b0),
			cfg_row(16'd0),
			row(CMD_SAMPLE, 1'b0, 1'b1, 32'h5555_5555, 1'b0, 32'sd0, 1'b0),
			row(CMD_QUERY,  1'b0, 1'b0, 32'hAAAA_AAAB, 1'b0, 32'sd0, 1'b0),
			cfg_row(16'd65535),
			row(CMD_SAMPLE, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 32'sd0, 1'b0),
			row(CMD_QUERY,  1'b1, 1'b1, 32'h5555_5555, 1'b0, 32'sd0, 1'b0)
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i]) begin
			if (dir_table[i].is_cfg)
				write_ppr(dir_table[i].ppr);
			else
				send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].want);
		end

		// resync the stream generator with the decoder state
		gen_stamp = mark_stamp;
		foreach (GRAY_ORDER[k])
			if (GRAY_ORDER[k] == enc_pair)
				gen_step = k;

		for (int p = 0; p < PHASES; p++) begin
			write_ppr(phase_ppr[p]);
			calm = (p == 3);
			for (int i = 0; i < phase_items[p]; i++) begin
				if (p == 4 && i == phase_items[p] / 2)
					wait_drained();
				send_item(next_random(phase_qpct[p]), 1'b0, '0);
			end
		end
		calm = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_quadrature_decoder_with_speed: clean");
		else
			$display("tb_quadrature_decoder_with_speed: errors");
		$finish;
	end

endmodule

// File: quadrature_decoder_with_speed.f
sv/qdec_pkg.sv
sv/qdec_ctrl.sv
sv/qdec_dp.sv
sv/quadrature_decoder_with_speed.sv
bench/tb_quadrature_decoder_with_speed.sv
